// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the modules of the core; the top module includes them.
// Each macro expects signals named clk and arst_n where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same clock cycle.
`define LAR_ASSERT_SAME(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("same-cycle check failed");

// Implication into the next clock cycle.
`define LAR_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("next-cycle check failed");

`endif

// ===== rtl/core/lar_pkg.sv =====
// Shared types and constants for the lagged additive random generator.
// No dependencies; the top, controller and datapath files of the core import this package.
package lar_pkg;

	localparam int RING_DEPTH_DEF   = 250;
	localparam int LAG_DISTANCE_DEF = 103;
	localparam int WORD_BITS_DEF    = 32;

	localparam int OUT_BITS = 32;

	localparam logic [31:0] SEED_XOR_FIRST  = 32'hA5B96384;
	localparam logic [31:0] SEED_XOR_SECOND = 32'h56F04021;
	localparam logic [31:0] MIX_FIRST_RST   = 32'h5c2582a4;
	localparam logic [31:0] MIX_SECOND_RST  = 32'h64dff8ca;
	localparam int MIX_MUL      = 13;
	localparam int MIX_SHIFT_A  = 9;
	localparam int MIX_SHIFT_B  = 13;
	localparam int MIX_ADD_B    = 13;
	localparam int SLOT_STEP    = 7;
	localparam int SLOT_FIRST   = 3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIX,
		ST_MUL,
		ST_FRD,
		ST_FWR,
		ST_DPOS,
		ST_DAHEAD,
		ST_DSUM,
		ST_DIV,
		ST_DOUT
	} state_t;

	typedef struct packed {
		logic load_seed;
		logic draw_start;
		logic mix_a;
		logic mul_step;
		logic force_rd;
		logic force_wr;
		logic rd_pos;
		logic rd_ahead;
		logic sum_wr;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_last;
		logic fill_last;
		logic force_last;
		logic div_last;
		logic range_zero;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/core/lagged_additive_random_generator.sv =====
// Lagged additive random generator. A reseed item (kind 0) gives no result:
// each ring word costs one mixer step on a shared 32x32 multiplier, then
// a read-modify-write pass forces one bit into WORD_BITS words over the
// registered-read ring RAM. A draw item (kind 1) gives one result from the
// bit-serial remainder unit; a range of zero skips it and returns the full
// word. The next item is taken when the current one is finished; a result
// waiting in the output register holds only a following draw at its last
// step.
module lagged_additive_random_generator #(
	parameter int RING_DEPTH   = lar_pkg::RING_DEPTH_DEF,
	parameter int LAG_DISTANCE = lar_pkg::LAG_DISTANCE_DEF,
	parameter int WORD_BITS    = lar_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] seed,
	input  logic [31:0] range,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] value
);

	import lar_pkg::*;

	`include "assert_macros.svh"

	cmd_t cmd;
	sts_t sts;

	lar_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind    (kind),
		.sts     (sts),
		.cmd     (cmd)
	);

	lar_dp #(
		.RING_DEPTH  (RING_DEPTH),
		.LAG_DISTANCE(LAG_DISTANCE),
		.WORD_BITS   (WORD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.seed     (seed),
		.range    (range),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value    (value)
	);

	// A transfer in starts work that blocks the next item
	`LAR_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
	// Never overwrite a result that has not been taken
	`LAR_ASSERT_SAME(a_no_overwrite, cmd.out_load, !(out_valid && out_stall))
	// A reseed never produces a result right away
	`LAR_ASSERT_NEXT(a_reseed_silent, cmd.load_seed, !cmd.out_load)

endmodule

// ===== rtl/core/lar_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lar_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/lar_ctrl.sv =====
// Sequencer for reseed and draw items of the lagged additive generator.
// Depends on lar_pkg for the state, command and status types.
module lar_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          kind,
	input  lar_pkg::sts_t sts,
	output lar_pkg::cmd_t cmd
);

	import lar_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nx = kind ? ST_DPOS : ST_MIX;
				end
			end
			ST_MIX:    state_nx = ST_MUL;
			ST_MUL: begin
				if (sts.mul_last) begin
					state_nx = sts.fill_last ? ST_FRD : ST_MIX;
				end
			end
			ST_FRD:    state_nx = ST_FWR;
			ST_FWR:    state_nx = sts.force_last ? ST_IDLE : ST_FRD;
			ST_DPOS:   state_nx = ST_DAHEAD;
			ST_DAHEAD: state_nx = ST_DSUM;
			ST_DSUM:   state_nx = sts.range_zero ? ST_DOUT : ST_DIV;
			ST_DIV: begin
				if (sts.div_last) begin
					state_nx = ST_DOUT;
				end
			end
			ST_DOUT: begin
				if (!sts.out_busy) begin
					state_nx = ST_IDLE;
				end
			end
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall       = 1'b0;
				cmd.load_seed  = in_valid && !kind;
				cmd.draw_start = in_valid && kind;
			end
			ST_MIX:    cmd.mix_a    = 1'b1;
			ST_MUL:    cmd.mul_step = 1'b1;
			ST_FRD:    cmd.force_rd = 1'b1;
			ST_FWR:    cmd.force_wr = 1'b1;
			ST_DPOS:   cmd.rd_pos   = 1'b1;
			ST_DAHEAD: cmd.rd_ahead = 1'b1;
			ST_DSUM:   cmd.sum_wr   = 1'b1;
			ST_DIV:    cmd.div_step = 1'b1;
			ST_DOUT:   cmd.out_load = !sts.out_busy;
			default:   cmd = '0;
		endcase
	end

endmodule

// ===== rtl/core/lar_dp.sv =====
// Datapath: mixer registers, ring indexes, ring RAM, divider and output register.
// Depends on lar_pkg and lar_ram.
module lar_dp #(
	parameter int RING_DEPTH   = lar_pkg::RING_DEPTH_DEF,
	parameter int LAG_DISTANCE = lar_pkg::LAG_DISTANCE_DEF,
	parameter int WORD_BITS    = lar_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lar_pkg::cmd_t cmd,
	output lar_pkg::sts_t sts,
	input  logic [31:0]   seed,
	input  logic [31:0]   range,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [31:0]   value
);

	import lar_pkg::*;

	localparam int PW = $clog2(RING_DEPTH);
	localparam int EW = $clog2(WORD_BITS);
	localparam logic [PW:0] DEPTH_X = (PW+1)'(RING_DEPTH);

	logic [WORD_BITS-1:0] mf_q, ms_q, wrd_q, dvd_q, rdata, rword, wdata, force_word;
	logic [WORD_BITS-1:0] keep_mask, top_bit, mf_next;
	logic [63:0]          acc_q, acc_next, prod, mf64, ms64;
	logic [31:0]          op_a, op_b, range_q, rem_q, out_q;
	logic [32:0]          trial, trial_sub;
	logic [1:0]           mul_cnt_q;
	logic [PW-1:0]        pos_q, fill_q, slot_q, raddr, waddr, pos_next, ahead;
	logic [PW:0]          pos_inc, ahead_sum, slot_sum;
	logic [EW-1:0]        e_q, div_cnt_q;
	logic                 seeded_q, out_valid_q, we;

	// Mixer first half
	assign mf_next = ((mf_q * WORD_BITS'(MIX_MUL)) + WORD_BITS'(1)
		^ (mf_q >> MIX_SHIFT_A)) + ms_q;

	// ms * mf in 32-bit partial products: lo*lo, then the two cross terms
	assign mf64 = 64'(mf_q);
	assign ms64 = 64'(ms_q);
	always_comb begin
		case (mul_cnt_q)
			2'd0:    begin op_a = ms64[31:0];  op_b = mf64[31:0];  end
			2'd1:    begin op_a = ms64[63:32]; op_b = mf64[31:0];  end
			default: begin op_a = ms64[31:0];  op_b = mf64[63:32]; end
		endcase
	end
	assign prod     = {32'b0, op_a} * {32'b0, op_b};
	assign acc_next = (mul_cnt_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'b0};

	assign pos_inc   = {1'b0, pos_q} + (PW+1)'(1);
	assign pos_next  = (pos_inc >= DEPTH_X) ? '0 : pos_inc[PW-1:0];
	assign ahead_sum = {1'b0, pos_q} + (PW+1)'(LAG_DISTANCE);
	assign ahead     = (ahead_sum >= DEPTH_X) ? PW'(ahead_sum - DEPTH_X) : ahead_sum[PW-1:0];
	assign slot_sum  = {1'b0, slot_q} + (PW+1)'(SLOT_STEP);

	// Ring reads as zero until the first reseed fills it
	assign rword = seeded_q ? rdata : '0;

	assign keep_mask  = {WORD_BITS{1'b1}} >> e_q;
	assign top_bit    = {1'b1, {(WORD_BITS-1){1'b0}}} >> e_q;
	assign force_word = (rword & keep_mask) | top_bit;

	always_comb begin
		raddr = pos_q;
		if (cmd.rd_ahead) begin
			raddr = ahead;
		end else if (cmd.force_rd) begin
			raddr = slot_q;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = wrd_q + rword;
		if (cmd.mul_step && sts.mul_last) begin
			we    = 1'b1;
			waddr = fill_q;
			wdata = mf_q;
		end else if (cmd.force_wr) begin
			we    = 1'b1;
			waddr = slot_q;
			wdata = force_word;
		end else if (cmd.sum_wr) begin
			we = 1'b1;
		end
	end

	lar_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign trial     = {rem_q, dvd_q[WORD_BITS-1]};
	assign trial_sub = trial - {1'b0, range_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mf_q        <= WORD_BITS'(MIX_FIRST_RST);
			ms_q        <= WORD_BITS'(MIX_SECOND_RST);
			pos_q       <= '0;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
			mul_cnt_q   <= '0;
			fill_q      <= '0;
			slot_q      <= '0;
			e_q         <= '0;
			div_cnt_q   <= '0;
		end else begin
			if (cmd.load_seed) begin
				mf_q     <= (WORD_BITS'(seed) - WORD_BITS'(1)) ^ WORD_BITS'(SEED_XOR_FIRST);
				ms_q     <= (WORD_BITS'(seed) + WORD_BITS'(1)) ^ WORD_BITS'(SEED_XOR_SECOND);
				pos_q    <= '0;
				fill_q   <= '0;
				seeded_q <= 1'b1;
			end
			if (cmd.mix_a) begin
				mf_q      <= mf_next;
				mul_cnt_q <= '0;
			end
			if (cmd.mul_step) begin
				mul_cnt_q <= mul_cnt_q + 2'd1;
				if (sts.mul_last) begin
					ms_q   <= (acc_next[WORD_BITS-1:0] + WORD_BITS'(MIX_ADD_B))
						^ (ms_q >> MIX_SHIFT_B);
					fill_q <= fill_q + PW'(1);
					e_q    <= '0;
					slot_q <= PW'(SLOT_FIRST % RING_DEPTH);
				end
			end
			if (cmd.force_wr) begin
				e_q    <= e_q + EW'(1);
				slot_q <= (slot_sum >= DEPTH_X) ? PW'(slot_sum - DEPTH_X) : slot_sum[PW-1:0];
			end
			if (cmd.draw_start) begin
				pos_q <= pos_next;
			end
			if (cmd.sum_wr) begin
				div_cnt_q <= '0;
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + EW'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_step) begin
			acc_q <= acc_next;
		end
		if (cmd.draw_start) begin
			range_q <= range;
		end
		if (cmd.rd_ahead) begin
			wrd_q <= rword;
		end
		if (cmd.sum_wr) begin
			dvd_q <= wdata;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			rem_q <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
		end
		if (cmd.out_load) begin
			out_q <= sts.range_zero ? dvd_q[31:0] : rem_q;
		end
	end

	assign sts.mul_last   = (mul_cnt_q == 2'd2);
	assign sts.fill_last  = (fill_q == PW'(RING_DEPTH - 1));
	assign sts.force_last = (e_q == EW'(WORD_BITS - 1));
	assign sts.div_last   = (div_cnt_q == EW'(WORD_BITS - 1));
	assign sts.range_zero = (range_q == '0);
	assign sts.out_busy   = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign value     = out_q;

endmodule

// ===== tb/tb_lagged_additive_random_generator.sv =====
// Testbench for the lagged additive random generator: drives reseed and draw
// transfers, predicts each drawn value from its own copy of the ring state.
// Depends on lar_pkg and the lagged_additive_random_generator RTL.
module tb_lagged_additive_random_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import lar_pkg::*;

	localparam int DEPTH = RING_DEPTH_DEF;
	localparam int LAG   = LAG_DISTANCE_DEF;
	localparam bit KIND_RESEED = 1'b0;
	localparam bit KIND_DRAW   = 1'b1;

	class ring_scoreboard;
		bit [31:0] ring [DEPTH];
		int unsigned pos;
		bit [31:0] mix_a, mix_b;
		bit [31:0] pending_values [$];
		int errors;

		function void clear();
			foreach (ring[i]) ring[i] = '0;
			pos = 0;
			mix_a = MIX_FIRST_RST;
			mix_b = MIX_SECOND_RST;
			pending_values.delete();
			errors = 0;
		endfunction

		function bit [31:0] mix_next();
			mix_a = ((mix_a * 32'(MIX_MUL) + 32'd1) ^ (mix_a >> MIX_SHIFT_A)) + mix_b;
			mix_b = (mix_b * mix_a + 32'(MIX_ADD_B)) ^ (mix_b >> MIX_SHIFT_B);
			return mix_a;
		endfunction

		function void note_input(bit k, bit [31:0] sd, bit [31:0] rg);
			bit [31:0] keep;
			bit [31:0] word;
			int unsigned slot, ahead;
			if (k == KIND_RESEED) begin
				mix_a = (sd - 32'd1) ^ SEED_XOR_FIRST;
				mix_b = (sd + 32'd1) ^ SEED_XOR_SECOND;
				pos = 0;
				for (int i = 0; i < DEPTH; i++) ring[i] = mix_next();
				keep = '1;
				for (int e = 0; e < 32; e++) begin
					slot = (SLOT_STEP * e + SLOT_FIRST) % DEPTH;
					ring[slot] &= keep;
					keep >>= 1;
					ring[slot] |= keep + 32'd1;
				end
			end else begin
				pos = (pos + 1 >= DEPTH) ? 0 : pos + 1;
				ahead = (pos + LAG) % DEPTH;
				word = ring[pos] + ring[ahead];
				ring[pos] = word;
				pending_values.push_back(rg == 0 ? word : word % rg);
			end
		endfunction

		function void check_value(bit [31:0] got);
			bit [31:0] want;
			if (pending_values.size() == 0) begin
				$error("value: no draw pending, actual %h", got);
				errors++;
				return;
			end
			want = pending_values.pop_front();
			if (got !== want) begin
				$error("value: expected %h, actual %h", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic kind = 0;
	logic [31:0] seed = '0;
	logic [31:0] range = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [31:0] value;

	ring_scoreboard draws = new();
	int send_idle_pct, recv_idle_pct;

	always #5 clk = ~clk;

	lagged_additive_random_generator dut (.*);

	// Result side: check on accept, then pick the next stall.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) draws.check_value(value);
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Valid stays up after a transfer until the next item or an idle cycle drops it.
	task automatic send_item(bit k, bit [31:0] sd, bit [31:0] rg);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		seed <= sd;
		range <= rg;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		draws.note_input(k, sd, rg);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (draws.pending_values.size() != 0) @(posedge clk);
	endtask

	function automatic bit [31:0] rand_range();
		case ($urandom_range(5))
			0: return '0;
			1: return $urandom_range(1, 16);
			2: return 32'hFFFFFFFF - $urandom_range(3);
			3: return 32'h1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		draws.clear();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: draws from the all-zero ring, then seed and range extremes.
		send_item(KIND_DRAW, '0, '0);
		send_item(KIND_DRAW, '1, 32'd1);
		send_item(KIND_RESEED, '0, 32'd5);
		send_item(KIND_DRAW, '1, '0);
		send_item(KIND_DRAW, '0, 32'd1);
		send_item(KIND_DRAW, '0, 32'hFFFFFFFF);
		send_item(KIND_DRAW, '0, 32'h80000000);
		send_item(KIND_RESEED, '1, '1);
		send_item(KIND_DRAW, '0, 32'd2);
		send_item(KIND_DRAW, '0, 32'h55555555);
		send_item(KIND_DRAW, '0, 32'hAAAAAAAA);
		send_item(KIND_RESEED, 32'h00000001, '0);
		send_item(KIND_RESEED, 32'h80000000, '0);
		for (int i = 0; i < 6; i++) send_item(KIND_DRAW, $urandom, '0);
		drain();

		// Random: three phases, the last without idling; reseeds are rare.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 47 : 0;
			recv_idle_pct = (ph == 0) ? 47 : (ph == 1) ? 38 : 0;
			for (int i = 0; i < 210; i++) begin
				if ($urandom_range(99) < 3)
					send_item(KIND_RESEED, $urandom, $urandom);
				else
					send_item(KIND_DRAW, $urandom, rand_range());
				if (i == 100) drain();
			end
		end

		drain();
		repeat (100) @(posedge clk);
		if (draws.errors == 0 && draws.pending_values.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
